// ===== sv/srm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants of the sorted run merger.
// ----------------------------------------------------------------------------
package srm_pkg;

	localparam int DEF_STORE_DEPTH = 1024;
	localparam int DEF_MAX_RUNS    = 16;

	localparam int VALUE_W  = 32;
	localparam int RUN_W    = 4;
	localparam int CFG_W    = 5;
	localparam int IN_DATA_W = 40;   // value + run_index, padded to bytes

	localparam logic [CFG_W-1:0] NUM_RUNS_RESET = CFG_W'(16);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_RD,
		ST_F_OUT,
		ST_M_START,
		ST_M_NEXT,
		ST_M_COPY,
		ST_M_RDLO,
		ST_M_RDHI,
		ST_M_CAP,
		ST_M_STEP,
		ST_M_WAIT
	} state_t;

endpackage

// ===== sv/srm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srm_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sorted_run_merger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_run_merger
// Collects signed values as sorted runs, merges them run by run, reads out.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser = op (0 load, 1 fetch), tlast = set_last,
// tdata = value and run index. A load with tlast starts the merge;
// s_tready stays low until all passes are done. Pass i merges the
// first prefix_i elements with run i over end_i = prefix_i+len_i
// elements: it copies them into the scratch RAM, run i reversed, then
// merges from both ends with the single compare unit and the one
// scratch read port, writing into the element RAM. An empty run is
// skipped. A fetch goes through ST_F_RD and ST_F_OUT; its result item
// is registered on m_*. Fetch before a merge or past the end gives
// tuser (empty) = 1 and zero data; tlast marks the last value.
// When m_tready is low, loads are still taken; a fetch waits in its output
// state until the output register frees up.
// cfg_* writes num_runs; always ready, write only while idle.
// Reset clears lengths, count, read pointer and merged flag, sets
// num_runs to 16. The RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_run_merger
	import srm_pkg::*;
#(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH,
	parameter int MAX_RUNS    = DEF_MAX_RUNS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // [31:0] value, [35:32] run_index
	input  logic                 s_tuser,   // [0] op
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [VALUE_W-1:0]   m_tdata,   // [31:0] sorted_value
	output logic                 m_tuser,   // [0] empty_res
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int CNTW = $clog2(STORE_DEPTH + 1);
	localparam int LIW  = $clog2(MAX_RUNS);
	localparam int RCW  = $clog2(MAX_RUNS + 1);
	localparam int NW   = RCW + CFG_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0]  num_runs_q;
	logic [CNTW-1:0]   len_q [MAX_RUNS];
	logic [CNTW-1:0]   count_q;
	logic [CNTW-1:0]   rp_q;
	logic              merged_q;
	logic [RCW-1:0]    idx_q;
	logic [CNTW-1:0]   prefix_q, left_q, end_q, t_q, lo_q, hi_q, k_q;
	logic [VALUE_W-1:0] lo_val_q, hi_val_q;
	logic              took_hi_q;
	logic              cp_v_s1;
	logic [CNTW-1:0]   cp_waddr_s1;
	logic              fetch_empty_q;
	logic              m_valid_q, m_last_q, m_user_q;
	logic [VALUE_W-1:0] m_data_q;

	// RAM ports
	logic               e_we, s_we;
	logic [AW-1:0]      e_waddr, e_raddr, s_waddr, s_raddr;
	logic [VALUE_W-1:0] e_wdata, e_rdata, s_rdata;

	// input decode
	logic [VALUE_W-1:0] in_value;
	logic [RUN_W-1:0]   in_run;
	logic               in_acc, load_acc, fetch_acc, keep;
	logic [NW-1:0]      n_ext, run_ext;
	logic [RCW-1:0]     n_act;
	logic [LIW-1:0]     run_idx;
	logic [CNTW-1:0]    eff_count;
	logic [CNTW-1:0]    len_cur, end_new;
	logic               out_free, take_hi, copy_go;

	assign in_value  = s_tdata[VALUE_W-1:0];
	assign in_run    = s_tdata[VALUE_W+RUN_W-1:VALUE_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign load_acc  = in_acc && (s_tuser == OP_LOAD);
	assign fetch_acc = in_acc && (s_tuser == OP_FETCH);
	assign cfg_ready = 1'b1;

	// active run count: clamp to [1, MAX_RUNS]
	always_comb begin
		n_ext = NW'(num_runs_q);
		priority if (n_ext > NW'(MAX_RUNS)) begin
			n_act = RCW'(MAX_RUNS);
		end else if (n_ext == '0) begin
			n_act = RCW'(1);
		end else begin
			n_act = n_ext[RCW-1:0];
		end
	end

	assign run_ext   = NW'(in_run);
	assign run_idx   = run_ext[LIW-1:0];
	assign eff_count = merged_q ? '0 : count_q;
	assign keep      = (run_ext < NW'(n_act)) && (eff_count < CNTW'(STORE_DEPTH));
	assign len_cur   = len_q[idx_q[LIW-1:0]];
	assign end_new   = prefix_q + len_cur;
	assign out_free  = !m_valid_q || m_tready;
	assign take_hi   = $signed(hi_val_q) < $signed(lo_val_q);
	assign copy_go   = (state_q == ST_M_COPY) && (t_q < end_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load_acc && s_tlast) begin
					state_d = ST_M_START;
				end else if (fetch_acc) begin
					state_d = ST_F_RD;
				end
			end
			ST_F_RD:    state_d = ST_F_OUT;
			ST_F_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_M_START: state_d = ST_M_NEXT;
			ST_M_NEXT: begin
				if (idx_q >= n_act) begin
					state_d = ST_IDLE;
				end else if (len_cur != '0) begin
					state_d = ST_M_COPY;
				end
			end
			ST_M_COPY: begin
				if (!(t_q < end_q)) begin
					state_d = ST_M_RDLO;
				end
			end
			ST_M_RDLO:  state_d = ST_M_RDHI;
			ST_M_RDHI:  state_d = ST_M_CAP;
			ST_M_CAP:   state_d = ST_M_STEP;
			ST_M_STEP: begin
				if (k_q + CNTW'(1) == end_q) begin
					state_d = ST_M_NEXT;
				end else begin
					state_d = ST_M_WAIT;
				end
			end
			ST_M_WAIT:  state_d = ST_M_STEP;
			default:    state_d = ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		e_we    = 1'b0;
		e_waddr = eff_count[AW-1:0];
		e_wdata = in_value;
		e_raddr = rp_q[AW-1:0];
		s_raddr = lo_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				e_we = load_acc && keep;
			end
			ST_M_COPY: begin
				e_raddr = t_q[AW-1:0];
			end
			ST_M_RDHI: begin
				s_raddr = hi_q[AW-1:0];
			end
			ST_M_STEP: begin
				e_we    = 1'b1;
				e_waddr = k_q[AW-1:0];
				e_wdata = take_hi ? hi_val_q : lo_val_q;
				s_raddr = take_hi ? AW'(hi_q - CNTW'(1)) : AW'(lo_q + CNTW'(1));
			end
			default: begin
			end
		endcase
	end

	// scratch write lands in the cycle after its element read
	assign s_we    = cp_v_s1;
	assign s_waddr = cp_waddr_s1[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			num_runs_q <= NUM_RUNS_RESET;
			for (int i = 0; i < MAX_RUNS; i++) begin
				len_q[i] <= '0;
			end
			count_q   <= '0;
			rp_q      <= '0;
			merged_q  <= 1'b0;
			idx_q     <= '0;
			cp_v_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cp_v_s1 <= copy_go;
			if (cfg_valid && cfg_ready) begin
				num_runs_q <= cfg_data;
			end
			if (load_acc) begin
				count_q <= eff_count + CNTW'(keep);
				if (merged_q) begin
					// new data set: drop old lengths
					for (int i = 0; i < MAX_RUNS; i++) begin
						len_q[i] <= (keep && run_idx == LIW'(i)) ? CNTW'(1) : '0;
					end
					rp_q     <= '0;
					merged_q <= 1'b0;
				end else if (keep) begin
					len_q[run_idx] <= len_q[run_idx] + CNTW'(1);
				end
			end
			if (state_q == ST_M_START) begin
				idx_q <= RCW'(1);
			end
			if (state_q == ST_M_NEXT) begin
				if (idx_q >= n_act) begin
					merged_q <= 1'b1;
					rp_q     <= '0;
				end else if (len_cur == '0) begin
					idx_q <= idx_q + RCW'(1);
				end
			end
			if (state_q == ST_M_STEP && k_q + CNTW'(1) == end_q) begin
				idx_q <= idx_q + RCW'(1);
			end
			if (state_q == ST_F_OUT && out_free && !fetch_empty_q) begin
				rp_q <= rp_q + CNTW'(1);
			end
			if (state_q == ST_F_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		cp_waddr_s1 <= (t_q < left_q) ? t_q : (end_q - CNTW'(1)) - (t_q - left_q);
		if (fetch_acc) begin
			fetch_empty_q <= !merged_q || (rp_q >= count_q);
		end
		unique case (state_q)
			ST_M_START: begin
				prefix_q <= len_q[0];
			end
			ST_M_NEXT: begin
				left_q   <= prefix_q;
				end_q    <= end_new;
				prefix_q <= end_new;
				t_q      <= '0;
				lo_q     <= '0;
				hi_q     <= end_new - CNTW'(1);
				k_q      <= '0;
			end
			ST_M_COPY: begin
				if (copy_go) begin
					t_q <= t_q + CNTW'(1);
				end
			end
			ST_M_RDHI: begin
				lo_val_q <= s_rdata;
			end
			ST_M_CAP: begin
				hi_val_q <= s_rdata;
			end
			ST_M_STEP: begin
				took_hi_q <= take_hi;
				k_q       <= k_q + CNTW'(1);
				if (take_hi) begin
					hi_q <= hi_q - CNTW'(1);
				end else begin
					lo_q <= lo_q + CNTW'(1);
				end
			end
			ST_M_WAIT: begin
				if (took_hi_q) begin
					hi_val_q <= s_rdata;
				end else begin
					lo_val_q <= s_rdata;
				end
			end
			ST_F_OUT: begin
				if (out_free) begin
					m_data_q <= fetch_empty_q ? '0 : e_rdata;
					m_user_q <= fetch_empty_q;
					m_last_q <= !fetch_empty_q && (rp_q + CNTW'(1) == count_q);
				end
			end
			default: begin
			end
		endcase
	end

	srm_ram #(
		.W     (VALUE_W),
		.DEPTH (STORE_DEPTH)
	) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	srm_ram #(
		.W     (VALUE_W),
		.DEPTH (STORE_DEPTH)
	) u_scratch_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (e_rdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(STORE_DEPTH))
		else $error("element count beyond store depth");

	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_M_STEP) |-> (lo_q <= hi_q) && (k_q < end_q))
		else $error("merge step with crossed pointers");

	a_copy_write: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_s1 |-> $past(state_q == ST_M_COPY))
		else $error("scratch write outside copy phase");

	a_out_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_user_q && m_last_q))
		else $error("empty item flagged as last");

	a_busy_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(load_acc && s_tlast) |=> !s_tready)
		else $error("ready during merge start");

endmodule
